/* rtl/ptm_pkg.sv */
package ptm_pkg;

  localparam int DIR_ENTRIES   = 1024;
  localparam int TABLE_ENTRIES = 1024;
  localparam int TABLE_POOL    = 16;

  localparam int DIR_IDX_W = $clog2(DIR_ENTRIES);
  localparam int ENT_IDX_W = $clog2(TABLE_ENTRIES);
  localparam int TBL_W     = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
  localparam int USED_W    = $clog2(TABLE_POOL + 1);
  localparam int POS_W     = TBL_W + ENT_IDX_W;
  localparam int TBL_WORDS = TABLE_POOL * TABLE_ENTRIES;
  localparam int SWEEP_W   = (DIR_IDX_W > ENT_IDX_W) ? DIR_IDX_W : ENT_IDX_W;

  localparam int VA_W    = 32;
  localparam int FRAME_W = 20;
  localparam int FLAGS_W = 12;
  localparam int WORD_W  = FRAME_W + FLAGS_W;

  typedef enum logic [1:0] {
    REQ_MAP    = 2'd0,
    REQ_UNMAP  = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOMAP     = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DIR,
    S_CLR,
    S_TBL,
    S_RESP
  } state_t;

  typedef struct packed {
    logic             present;
    logic [TBL_W-1:0] tbl;
  } dir_entry_t;

  typedef struct packed {
    logic                 we;
    logic [DIR_IDX_W-1:0] waddr;
    dir_entry_t           wdata;
    logic [DIR_IDX_W-1:0] raddr;
  } dir_port_t;

  typedef struct packed {
    logic              we;
    logic [POS_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic [POS_W-1:0]  raddr;
  } tbl_port_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FRAME_W-1:0] frame;
  } result_t;

endpackage

/* rtl/ptm_dir_mem.sv */
module ptm_dir_mem (
  input  logic               clk,
  input  ptm_pkg::dir_port_t port,
  output ptm_pkg::dir_entry_t rdata
);
  import ptm_pkg::*;

  dir_entry_t mem [DIR_ENTRIES];

  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr] <= port.wdata;
    end
    rdata <= mem[port.raddr];
  end

endmodule

/* rtl/ptm_tbl_mem.sv */
module ptm_tbl_mem (
  input  logic                          clk,
  input  ptm_pkg::tbl_port_t            port,
  output logic [ptm_pkg::WORD_W-1:0]    rdata
);
  import ptm_pkg::*;

  logic [WORD_W-1:0] mem [TBL_WORDS];

  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr] <= port.wdata;
    end
    rdata <= mem[port.raddr];
  end

endmodule

/* rtl/ptm_ctrl.sv */
module ptm_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     req_type,
  input  logic [ptm_pkg::VA_W-1:0]       virt_addr,
  input  logic [ptm_pkg::VA_W-1:0]       phys_addr,
  input  logic [ptm_pkg::FLAGS_W-1:0]    page_flags,
  input  logic                           out_free,
  output logic                           res_load,
  output ptm_pkg::result_t               res,
  output ptm_pkg::dir_port_t             dir_port,
  input  ptm_pkg::dir_entry_t            dir_rdata,
  output ptm_pkg::tbl_port_t             tbl_port,
  input  logic [ptm_pkg::WORD_W-1:0]     tbl_rdata
);
  import ptm_pkg::*;

  state_t               state, state_next;
  logic [SWEEP_W-1:0]   cnt;
  logic [1:0]           req_q;
  logic [DIR_IDX_W-1:0] dir_idx;
  logic [ENT_IDX_W-1:0] ent_idx;
  logic [WORD_W-1:0]    map_word;
  logic [TBL_W-1:0]     tbl_q;
  logic [USED_W-1:0]    used;
  logic [1:0]           res_status;
  logic [FRAME_W-1:0]   res_frame;

  logic is_map, is_unmap, is_lookup;
  logic hit, room, alloc, dir_last, clr_last;

  assign is_map    = (req_q == REQ_MAP);
  assign is_unmap  = (req_q == REQ_UNMAP);
  assign is_lookup = (req_q == REQ_LOOKUP);
  assign hit       = dir_rdata.present &&
                     ({1'b0, dir_rdata.tbl} < (TBL_W + 1)'(TABLE_POOL));
  assign room      = (used < USED_W'(TABLE_POOL));
  assign alloc     = (state == S_DIR) && !hit && is_map && room;
  assign dir_last  = (cnt[DIR_IDX_W-1:0] == DIR_IDX_W'(DIR_ENTRIES - 1));
  assign clr_last  = (cnt[ENT_IDX_W-1:0] == ENT_IDX_W'(TABLE_ENTRIES - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (dir_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_DIR;
      end
      S_DIR: begin
        if (alloc) state_next = S_CLR;
        else if (hit && is_lookup) state_next = S_TBL;
        else state_next = S_RESP;
      end
      S_CLR: begin
        if (clr_last) state_next = S_RESP;
      end
      S_TBL: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  always_comb begin
    dir_port       = '0;
    dir_port.raddr = virt_addr[VA_W-1 -: DIR_IDX_W];
    tbl_port       = '0;
    tbl_port.raddr = {dir_rdata.tbl, ent_idx};
    in_stall       = 1'b1;
    res_load       = 1'b0;
    unique case (state)
      S_INIT: begin
        dir_port.we    = 1'b1;
        dir_port.waddr = cnt[DIR_IDX_W-1:0];
      end
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_DIR: begin
        if (hit) begin
          tbl_port.waddr = {dir_rdata.tbl, ent_idx};
          if (is_map) begin
            tbl_port.we    = 1'b1;
            tbl_port.wdata = map_word;
          end else if (is_unmap) begin
            tbl_port.we = 1'b1;
          end
        end else if (alloc) begin
          dir_port.we            = 1'b1;
          dir_port.waddr         = dir_idx;
          dir_port.wdata.present = 1'b1;
          dir_port.wdata.tbl     = used[TBL_W-1:0];
        end
      end
      S_CLR: begin
        tbl_port.we    = 1'b1;
        tbl_port.waddr = {tbl_q, cnt[ENT_IDX_W-1:0]};
        tbl_port.wdata = (cnt[ENT_IDX_W-1:0] == ent_idx) ? map_word : '0;
      end
      S_TBL: begin
      end
      S_RESP: begin
        res_load = out_free;
      end
      default: begin
      end
    endcase
  end

  assign res.status = res_status;
  assign res.frame  = res_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
      used  <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state == S_INIT || state == S_CLR) ? cnt + 1'b1 : '0;
      if (alloc) begin
        used <= used + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_q    <= req_type;
      dir_idx  <= virt_addr[VA_W-1 -: DIR_IDX_W];
      ent_idx  <= virt_addr[VA_W-DIR_IDX_W-1 -: ENT_IDX_W];
      map_word <= {phys_addr[VA_W-1 -: FRAME_W], page_flags};
    end
    if (alloc) begin
      tbl_q <= used[TBL_W-1:0];
    end
    if (state == S_DIR) begin
      res_frame <= '0;
      if (!hit && is_map && !room) res_status <= ST_EXHAUSTED;
      else if (!hit && is_lookup) res_status <= ST_NOMAP;
      else res_status <= ST_OK;
    end else if (state == S_TBL) begin
      if (tbl_rdata != '0) begin
        res_status <= ST_OK;
        res_frame  <= tbl_rdata[WORD_W-1 -: FRAME_W];
      end else begin
        res_status <= ST_NOMAP;
        res_frame  <= '0;
      end
    end
  end

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(TABLE_POOL))
    else $error("table pool count overrun");

  a_clr_has_table: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR |-> used != '0)
    else $error("table clear without allocation");

  a_dir_wr_alloc: assert property (@(posedge clk) disable iff (rst)
    (dir_port.we && state == S_DIR) |=> state == S_CLR)
    else $error("directory update not followed by table clear");

  a_clr_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR && clr_last) |=> state == S_RESP)
    else $error("table clear did not finish");

endmodule

/* rtl/two_level_page_table_manager.sv */
// channel | handshake          | fields
// in      | in_valid/in_stall   | req_type, virt_addr, phys_addr, page_flags
// out     | out_valid/out_stall | status, phys_frame
//
// After rst the directory is swept clear, one slot a cycle, with in_stall high.
// Map or unmap to a present table, or an absent-slot request: directory read, then the result step.
// Lookup of a present table: directory read, then table read, then the result step.
// Map that takes a fresh table: directory read, then the clear sweep of that table, then the result step.
// One result register on the output; the sequencer holds its last step while out_stall
// keeps that register full, and in_stall stays high until the request retires.
module two_level_page_table_manager (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  req_type,
  input  logic [ptm_pkg::VA_W-1:0]    virt_addr,
  input  logic [ptm_pkg::VA_W-1:0]    phys_addr,
  input  logic [ptm_pkg::FLAGS_W-1:0] page_flags,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [ptm_pkg::FRAME_W-1:0] phys_frame
);
  import ptm_pkg::*;

  dir_port_t         dir_port;
  dir_entry_t        dir_rdata;
  tbl_port_t         tbl_port;
  logic [WORD_W-1:0] tbl_rdata;
  logic              out_free;
  logic              res_load;
  result_t           res;

  assign out_free = !out_valid || !out_stall;

  ptm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .virt_addr  (virt_addr),
    .phys_addr  (phys_addr),
    .page_flags (page_flags),
    .out_free   (out_free),
    .res_load   (res_load),
    .res        (res),
    .dir_port   (dir_port),
    .dir_rdata  (dir_rdata),
    .tbl_port   (tbl_port),
    .tbl_rdata  (tbl_rdata)
  );

  ptm_dir_mem u_dir_mem (
    .clk   (clk),
    .port  (dir_port),
    .rdata (dir_rdata)
  );

  ptm_tbl_mem u_tbl_mem (
    .clk   (clk),
    .port  (tbl_port),
    .rdata (tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status     <= res.status;
      phys_frame <= res.frame;
    end
  end

endmodule
